### rtl/bez_pkg.sv
`default_nettype none

package bez_pkg;

   // Fixed field widths.
   localparam int COORD_W = 32;
   localparam int PARAM_W = 17;
   localparam int LANES   = 3;
   localparam int POINT_W = COORD_W * LANES;

   // Curve parameter value that stands for 1.0.
   localparam logic [PARAM_W-1:0] PARAM_ONE = 17'd65536;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_we;   // store the incoming control point
      logic t_load;    // capture the curve parameter
      logic cap_a;     // take the memory read data as the left operand
      logic cap_diff;  // take the right operand and form the difference
      logic do_mul;    // multiply the difference by the parameter
      logic blend_we;  // write the lerp result back, shift right operand to left
      logic out_load;  // move the memory read data into the output register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_busy;  // output register holds a word that is not taken this cycle
   } status_type;

endpackage

`default_nettype wire

### rtl/bez_ram.sv
`default_nettype none

module bez_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire               clock,
   input  wire               we,
   input  wire  [ADDR_W-1:0] waddr,
   input  wire  [WIDTH-1:0]  wdata,
   input  wire  [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

`default_nettype wire

### rtl/bez_ctrl.sv
`default_nettype none

module bez_ctrl #(
   parameter int MAX_POINTS = 16,
   localparam int IDX_W = $clog2(MAX_POINTS)
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_tvalid,
   input  wire                  req_tlast,
   output logic                 req_tready,
   input  bez_pkg::status_type  status,
   output bez_pkg::cmd_type     cmd,
   output logic [IDX_W-1:0]     waddr,
   output logic [IDX_W-1:0]     raddr,
   output logic                 ovf_flag
);

   import bez_pkg::*;

   localparam int CNT_W = $clog2(MAX_POINTS + 1);

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_FETCH_A,
      ST_LATCH_A,
      ST_FETCH_B,
      ST_DIFF,
      ST_PROD,
      ST_WRITE,
      ST_FIN_RD,
      ST_FIN_WAIT
   } state_type;

   state_type        state_ff;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] level_ff;
   logic [IDX_W-1:0] idx_ff;
   logic             ovf_ff;

   logic             accept;
   logic             fits;
   logic [CNT_W-1:0] count_in;
   logic             level_end;

   assign accept    = req_tvalid & req_tready;
   assign fits      = count_ff < CNT_W'(MAX_POINTS);
   assign count_in  = count_ff + CNT_W'(fits);
   assign level_end = (CNT_W'(idx_ff) + CNT_W'(2)) == level_ff;
   assign ovf_flag  = ovf_ff;

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      waddr      = idx_ff;
      raddr      = '0;
      case (state_ff)
         ST_LOAD: begin
            req_tready = 1'b1;
            waddr      = count_ff[IDX_W-1:0];
            if (accept) begin
               cmd.load_we = fits;
               cmd.t_load  = req_tlast;
            end
         end
         ST_LATCH_A: cmd.cap_a = 1'b1;
         ST_FETCH_B: raddr = idx_ff + IDX_W'(1);
         ST_DIFF:    cmd.cap_diff = 1'b1;
         ST_PROD:    cmd.do_mul = 1'b1;
         ST_WRITE:   cmd.blend_we = 1'b1;
         ST_FIN_WAIT: cmd.out_load = ~status.out_busy;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         count_ff <= '0;
         level_ff <= '0;
         idx_ff   <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         case (state_ff)
            ST_LOAD: begin
               if (accept) begin
                  ovf_ff <= ovf_ff | ~fits;
                  if (req_tlast) begin
                     count_ff <= '0;
                     level_ff <= count_in;
                     idx_ff   <= '0;
                     state_ff <= (count_in == CNT_W'(1)) ? ST_FIN_RD : ST_FETCH_A;
                  end else begin
                     count_ff <= count_in;
                  end
               end
            end
            ST_FETCH_A: state_ff <= ST_LATCH_A;
            ST_LATCH_A: state_ff <= ST_FETCH_B;
            ST_FETCH_B: state_ff <= ST_DIFF;
            ST_DIFF:    state_ff <= ST_PROD;
            ST_PROD:    state_ff <= ST_WRITE;
            ST_WRITE: begin
               if (level_end) begin
                  level_ff <= level_ff - CNT_W'(1);
                  idx_ff   <= '0;
                  state_ff <= (level_ff == CNT_W'(2)) ? ST_FIN_RD : ST_FETCH_A;
               end else begin
                  idx_ff   <= idx_ff + IDX_W'(1);
                  state_ff <= ST_FETCH_B;
               end
            end
            ST_FIN_RD: state_ff <= ST_FIN_WAIT;
            ST_FIN_WAIT: begin
               if (!status.out_busy) begin
                  ovf_ff   <= 1'b0;
                  state_ff <= ST_LOAD;
               end
            end
            default: state_ff <= ST_LOAD;
         endcase
      end
   end

endmodule

`default_nettype wire

### rtl/bez_datapath.sv
`default_nettype none

module bez_datapath #(
   parameter int MAX_POINTS = 16,
   localparam int IDX_W = $clog2(MAX_POINTS)
) (
   input  wire                            clock,
   input  wire                            reset,
   input  bez_pkg::cmd_type               cmd,
   output bez_pkg::status_type            status,
   input  wire  [IDX_W-1:0]               waddr,
   input  wire  [IDX_W-1:0]               raddr,
   input  wire  [bez_pkg::POINT_W-1:0]    in_point,
   input  wire  [bez_pkg::PARAM_W-1:0]    in_param,
   input  wire                            ovf_flag,
   output logic                           rsp_tvalid,
   input  wire                            rsp_tready,
   output logic [bez_pkg::POINT_W-1:0]    rsp_point,
   output logic                           rsp_flag
);

   import bez_pkg::*;

   localparam int DIFF_W = COORD_W + 1;
   localparam int PROD_W = DIFF_W + PARAM_W + 1;

   logic [POINT_W-1:0]            rd_data;
   logic [POINT_W-1:0]            wr_data;
   logic [LANES-1:0][COORD_W-1:0] rd_lane;
   logic [LANES-1:0][COORD_W-1:0] blend;
   logic [LANES-1:0][COORD_W-1:0] a_ff;
   logic [LANES-1:0][COORD_W-1:0] b_ff;
   logic [LANES-1:0][DIFF_W-1:0]  diff_ff;
   logic [LANES-1:0][PROD_W-1:0]  prod_ff;
   logic [PARAM_W-1:0]            t_ff;
   logic                          valid_ff;
   logic [POINT_W-1:0]            res_ff;
   logic                          flag_ff;

   assign rd_lane = rd_data;

   // Sum of the left operand and the product floored by 16 bits; the upper
   // bits of the full sum are known to be a sign extension.
   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         blend[k] = a_ff[k] + prod_ff[k][COORD_W+15:16];
      end
   end

   assign wr_data = cmd.load_we ? in_point : blend;

   bez_ram #(
      .WIDTH (POINT_W),
      .DEPTH (MAX_POINTS)
   ) u_store (
      .clock (clock),
      .we    (cmd.load_we | cmd.blend_we),
      .waddr (waddr),
      .wdata (wr_data),
      .raddr (raddr),
      .rdata (rd_data)
   );

   always_ff @(posedge clock) begin
      if (cmd.t_load) begin
         t_ff <= (in_param > PARAM_ONE) ? PARAM_ONE : in_param;
      end
      if (cmd.cap_a) begin
         a_ff <= rd_lane;
      end
      if (cmd.blend_we) begin
         a_ff <= b_ff;
      end
      for (int k = 0; k < LANES; k++) begin
         if (cmd.cap_diff) begin
            b_ff[k]    <= rd_lane[k];
            diff_ff[k] <= {rd_lane[k][COORD_W-1], rd_lane[k]} - {a_ff[k][COORD_W-1], a_ff[k]};
         end
         if (cmd.do_mul) begin
            prod_ff[k] <= PROD_W'($signed(diff_ff[k]) * $signed({1'b0, t_ff}));
         end
      end
      if (cmd.out_load) begin
         res_ff  <= rd_data;
         flag_ff <= ovf_flag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   assign status.out_busy = valid_ff & ~rsp_tready;
   assign rsp_tvalid      = valid_ff;
   assign rsp_point       = res_ff;
   assign rsp_flag        = flag_ff;

endmodule

`default_nettype wire

### rtl/bezier_de_casteljau_eval.sv
// Bezier curve evaluator, de Casteljau reduction in fixed point.
// The request channel carries one control point per word (x, y, z in signed
// Q16.16) and is ready whenever the block is loading points, one word a cycle.
// The word with tlast set ends the curve; its curve parameter t (Q1.16, values
// above 1.0 are clamped to 1.0) is used for the whole evaluation.
// Points beyond MAX_POINTS are dropped and the result carries a flag in tuser.
// After the last word the block stops taking words and reduces the stored
// points level by level through one point memory with a single read port and
// three lerp lanes (subtract, then multiply, then add and write back).
// Each level first fetches its first point; each lerp then fetches its right
// point, subtracts, multiplies and writes back; a final read moves the last
// remaining point into the output register.
// The result sits in an output register; while it waits for the receiver the
// next curve's points are already taken, and only a second result stalls.
// Reset is synchronous: it empties the point count and the result register.
// The point memory itself is not cleared; only entries of the current curve
// are ever read.
`default_nettype none

module bezier_de_casteljau_eval #(
   parameter int MAX_POINTS = 16
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   // point_x [31:0], point_y [63:32], point_z [95:64], curve_param [112:96], zero fill
   input  wire  [119:0] req_tdata,
   // last_point
   input  wire          req_tlast,
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   // result_x [31:0], result_y [63:32], result_z [95:64]
   output logic [95:0]  rsp_tdata,
   // too_many_points [0]
   output logic [0:0]   rsp_tuser
);

   import bez_pkg::*;

   localparam int IDX_W = $clog2(MAX_POINTS);

   cmd_type          cmd;
   status_type       status;
   logic [IDX_W-1:0] waddr;
   logic [IDX_W-1:0] raddr;
   logic             ovf_flag;
   logic             rsp_flag;

   // Sequencer: point count, reduction level and index, overflow flag.
   bez_ctrl #(
      .MAX_POINTS (MAX_POINTS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd),
      .waddr      (waddr),
      .raddr      (raddr),
      .ovf_flag   (ovf_flag)
   );

   // Point memory, lerp lanes and the output register.
   bez_datapath #(
      .MAX_POINTS (MAX_POINTS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .waddr      (waddr),
      .raddr      (raddr),
      .in_point   (req_tdata[POINT_W-1:0]),
      .in_param   (req_tdata[POINT_W+PARAM_W-1:POINT_W]),
      .ovf_flag   (ovf_flag),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_point  (rsp_tdata),
      .rsp_flag   (rsp_flag)
   );

   assign rsp_tuser[0] = rsp_flag;

endmodule

`default_nettype wire

### test/bezier_de_casteljau_eval_tb.sv
`timescale 1ns / 1ps

module bezier_de_casteljau_eval_tb;
   import bez_pkg::*;

   localparam int MAX_PTS = 16;
   // The drain wait at the end covers the longest evaluation, that of a full
   // store, with some margin.
   localparam int DRAIN_CYCLES = 2 * MAX_PTS * MAX_PTS + 100;
   // Length of the one long receiver hold-off, in cycles.
   localparam int LONG_HOLD = 600;
   // Random points before the final part without idling.
   localparam int RANDOM_POINTS = 1350;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   // point_x [31:0], point_y [63:32], point_z [95:64], curve_param [112:96], zero fill
   logic [119:0] req_tdata = '0;
   // last_point
   logic         req_tlast = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   // result_x [31:0], result_y [63:32], result_z [95:64]
   logic [95:0]  rsp_tdata;
   // too_many_points [0]
   logic [0:0]   rsp_tuser;

   bezier_de_casteljau_eval #(
      .MAX_POINTS(MAX_PTS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // One evaluated curve point as the block should emit it.
   typedef struct {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] z;
      logic               dropped;
   } curve_point_type;

   // Curve points still owed by the block, oldest first.
   curve_point_type pending_curve_points[$];

   // Our own copy of the block state: the point store per lane (x, y, z),
   // how many points of the current curve it holds, and whether any point
   // of the current curve was dropped because the store was full.
   logic signed [COORD_W-1:0] point_mem [LANES][MAX_PTS];
   int unsigned               points_held = 0;
   bit                        points_dropped = 1'b0;

   // Run statistics and the mismatch count.
   int error_count = 0;
   int words_sent = 0;
   int curves_sent = 0;
   int overflow_curves = 0;
   int results_checked = 0;

   // Idling is switched off for the last part of the run.
   bit idle_on = 1'b1;
   // Set by the pressure test; the receiver turns it into a long hold-off.
   bit hold_req = 1'b0;

   // One lerp step: a + floor((b - a) * t / 65536). The difference needs 33
   // bits and the product at most 50, so a 64-bit signed value with an
   // arithmetic shift gives the floor directly.
   function automatic logic signed [COORD_W-1:0] lerp_q16(
      input logic signed [COORD_W-1:0] a,
      input logic signed [COORD_W-1:0] b,
      input longint                    t
   );
      longint diff;
      longint sum;
      diff = longint'(b) - longint'(a);
      sum = longint'(a) + ((diff * t) >>> 16);
      return sum[COORD_W-1:0];
   endfunction

   // De Casteljau reduction of one coordinate lane over the held points.
   function automatic logic signed [COORD_W-1:0] reduce_lane(input int lane, input longint t);
      logic signed [COORD_W-1:0] work [MAX_PTS];
      int n;
      n = points_held;
      for (int i = 0; i < n; i++) work[i] = point_mem[lane][i];
      for (int level = n; level > 1; level--) begin
         for (int i = 0; i + 1 < level; i++) begin
            work[i] = lerp_q16(work[i], work[i + 1], t);
         end
      end
      return work[0];
   endfunction

   // Update the predicted state with one accepted word and, on the last word
   // of a curve, queue the curve point the block must produce.
   task automatic absorb_point(
      input logic [COORD_W-1:0] x,
      input logic [COORD_W-1:0] y,
      input logic [COORD_W-1:0] z,
      input logic [PARAM_W-1:0] t,
      input logic               last
   );
      curve_point_type cp;
      longint          t_eff;
      if (points_held < MAX_PTS) begin
         point_mem[0][points_held] = x;
         point_mem[1][points_held] = y;
         point_mem[2][points_held] = z;
         points_held++;
      end else begin
         points_dropped = 1'b1;
      end
      if (last) begin
         // Values of t above 1.0 are clamped to 1.0.
         t_eff = (t > PARAM_ONE) ? longint'(PARAM_ONE) : longint'(t);
         cp.x = reduce_lane(0, t_eff);
         cp.y = reduce_lane(1, t_eff);
         cp.z = reduce_lane(2, t_eff);
         cp.dropped = points_dropped;
         pending_curve_points.push_back(cp);
         curves_sent++;
         if (points_dropped) overflow_curves++;
         points_held = 0;
         points_dropped = 1'b0;
      end
   endtask

   // Send one control point word. An optional idle burst comes first; valid
   // then stays high until the word is taken, and it is not lowered here, so
   // back-to-back words never see a low and a high in the same step.
   task automatic send_point(
      input logic [COORD_W-1:0] x,
      input logic [COORD_W-1:0] y,
      input logic [COORD_W-1:0] z,
      input logic [PARAM_W-1:0] t,
      input logic               last
   );
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'b0, t, z, y, x};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      absorb_point(x, y, z, t, last);
      words_sent++;
   endtask

   task automatic stop_sending();
      req_tvalid <= 1'b0;
      req_tlast  <= 1'b0;
   endtask

   // A coordinate biased toward the extremes and small magnitudes, where
   // lerp rounding and the sign of the difference matter most.
   function automatic logic [COORD_W-1:0] random_coord();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'h0000_0000;
         3: return 32'hffff_ffff;
         4: return 32'($urandom_range(0, 511)) - 32'd256;
         default: return $urandom;
      endcase
   endfunction

   // Curve parameter: endpoints, clamped values above 1.0 and random values.
   function automatic logic [PARAM_W-1:0] random_param();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return PARAM_ONE;
         2: return PARAM_W'($urandom_range(65537, 131071));
         default: return PARAM_W'($urandom_range(0, 65535));
      endcase
   endfunction

   // Send a whole curve of n points with random content. Words other than the
   // last carry a random parameter, which the block must ignore.
   task automatic send_random_curve(input int n);
      for (int i = 0; i < n; i++) begin
         if (i == n - 1) begin
            send_point(random_coord(), random_coord(), random_coord(), random_param(), 1'b1);
         end else begin
            send_point(random_coord(), random_coord(), random_coord(),
                       PARAM_W'($urandom_range(0, 131071)), 1'b0);
         end
      end
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      $display("%0t: mismatch in %s: expected %h, got %h", $realtime, what, want, got);
      error_count++;
   endtask

   // Receiver: checks each taken result word against the oldest owed curve
   // point, then decides tready for the next cycle. The long hold-off is
   // counted here, separately from the short random bursts.
   int hold_left = 0;
   int burst_left = 0;

   always @(posedge clock) begin
      curve_point_type cp;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_curve_points.size() == 0) begin
            report_mismatch("result word with no curve pending", 32'h0, rsp_tdata[31:0]);
         end else begin
            cp = pending_curve_points.pop_front();
            if (rsp_tdata[31:0] !== cp.x) report_mismatch("result_x", cp.x, rsp_tdata[31:0]);
            if (rsp_tdata[63:32] !== cp.y) report_mismatch("result_y", cp.y, rsp_tdata[63:32]);
            if (rsp_tdata[95:64] !== cp.z) report_mismatch("result_z", cp.z, rsp_tdata[95:64]);
            if (rsp_tuser[0] !== cp.dropped) begin
               report_mismatch("too_many_points", 32'(cp.dropped), 32'(rsp_tuser[0]));
            end
            results_checked++;
         end
      end
      if (hold_req) begin
         hold_left = LONG_HOLD;
         hold_req = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (burst_left > 0) begin
         burst_left--;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
         burst_left = $urandom_range(1, 3) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Directed cases: a single point, both ends of t, extreme coordinates with
   // differences of both signs, rounding toward minus infinity, clamping of
   // t above 1.0, and a full store whose last word is dropped.
   task automatic test_directed();
      // A single point comes back unchanged whatever t is.
      send_point(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 17'd12345, 1'b1);
      // t = 0 selects the first point.
      send_point(32'h8000_0000, 32'h7fff_ffff, 32'h1234_5678, PARAM_W'(131071), 1'b0);
      send_point(32'h7fff_ffff, 32'h8000_0000, 32'hedcb_a988, '0, 1'b1);
      // t = 1.0 selects the last point, across the full signed range.
      send_point(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, '0, 1'b0);
      send_point(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, PARAM_ONE, 1'b1);
      // Smallest t: 0 -> -1 must floor to -1, min -> max adds 65535.
      send_point(32'h0000_0000, 32'h8000_0000, 32'h7fff_ffff, '0, 1'b0);
      send_point(32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000, 17'd1, 1'b1);
      // t just above 1.0 is clamped.
      send_point(32'h0001_0000, 32'hffff_0000, 32'h4000_0000, '0, 1'b0);
      send_point(32'hfffe_0000, 32'h0003_8000, 32'hc000_0000, 17'd65537, 1'b1);
      // Sixteen points fill the store; the last word is dropped but its t is used.
      for (int i = 0; i < MAX_PTS; i++) begin
         send_point(random_coord(), random_coord(), random_coord(), PARAM_ONE, 1'b0);
      end
      send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, PARAM_W'(131071), 1'b1);
   endtask

   // The receiver stops for a long stretch while several curves are offered,
   // so the result register fills and the block must stall its input.
   task automatic test_backpressure();
      hold_req = 1'b1;
      for (int c = 0; c < 4; c++) send_random_curve(6);
   endtask

   // Random curves, mostly short, some filling the store, some overflowing it.
   task automatic test_random_curves();
      int start;
      int n;
      start = words_sent;
      while (words_sent - start < RANDOM_POINTS) begin
         case ($urandom_range(0, 9)) inside
            [0:6]: n = $urandom_range(1, 8);
            [7:8]: n = $urandom_range(9, MAX_PTS);
            default: n = $urandom_range(MAX_PTS + 1, MAX_PTS + 4);
         endcase
         send_random_curve(n);
      end
   endtask

   // Final stretch at full rate on both sides.
   task automatic test_full_rate();
      idle_on = 1'b0;
      for (int c = 0; c < 25; c++) send_random_curve($urandom_range(1, 12));
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      test_random_curves();
      test_full_rate();
      stop_sending();
      // Wait for every owed curve point, then watch a while for stray words.
      wait (pending_curve_points.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d control point words in %0d curves, %0d of them with dropped points.",
               words_sent, curves_sent, overflow_curves);
      $display("Checked %0d evaluated curve points, %0d mismatches.",
               results_checked, error_count);
      if (error_count == 0) begin
         $display("bezier_de_casteljau_eval_tb: PASS");
      end else begin
         $display("bezier_de_casteljau_eval_tb: FAIL");
      end
      $finish;
   end

   // Guard against a hung handshake: far beyond the slowest correct run.
   initial begin
      #5_000_000;
      $display("Timed out with %0d curve points still owed.", pending_curve_points.size());
      $display("bezier_de_casteljau_eval_tb: FAIL");
      $finish;
   end

endmodule
